/* hw/rtl/kepler_pkg.sv */
// kepler_pkg: shared constants, state encoding and arctangent table for the
// bisection kepler solver. no dependencies.
package kepler_pkg;

    localparam int ANGLE_FRAC_BITS = 28;
    localparam int ECC_FRAC_BITS   = 16;
    localparam int ANGLE_W         = 32;
    localparam int ECC_W           = 16;
    localparam int COUNT_W         = 6;
    localparam int CORDIC_STAGES   = 30;
    localparam int STAGE_W         = 5;
    localparam int Q30_W           = 34;   // angle in q30, unsigned
    localparam int RED_W           = 36;   // signed reduction/residual angle
    localparam int XY_W            = 34;   // signed cordic vector
    localparam int ES_W            = 33;   // scaled sine magnitude
    localparam int F_W             = 38;   // signed kepler function

    localparam logic [ANGLE_W-1:0] FOUR_PI_ANGLE = 32'hC90F_DAA2;
    localparam logic [RED_W-1:0]   TWO_PI_Q30    = 36'd6746518852;
    localparam logic [RED_W-1:0]   PI_Q30        = 36'd3373259426;
    localparam logic [RED_W-1:0]   HALF_PI_Q30   = 36'd1686629713;
    localparam logic [XY_W-1:0]    CORDIC_GAIN   = 34'd652032874;
    localparam logic [COUNT_W-1:0] STEP_LIMIT    = 6'd63;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ECCENTRICITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 1'd1;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_CHECK  = 10'b00_0000_0010,
        ST_LOAD   = 10'b00_0000_0100,
        ST_REDUCE = 10'b00_0000_1000,
        ST_FOLD   = 10'b00_0001_0000,
        ST_ROTATE = 10'b00_0010_0000,
        ST_SCALE  = 10'b00_0100_0000,
        ST_SIGN   = 10'b00_1000_0000,
        ST_UPDATE = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

    function automatic logic [31:0] atan_lut(input logic [STAGE_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/kepler_equation_bisection_solver.sv */
// kepler_equation_bisection_solver: bisection solver for E - e*sin(E) = M
// with a shared one-stage-per-cycle cordic. depends on kepler_pkg.
//
// usage: write eccentricity (index 0, q0.16) and tolerance (index 1, q4.28)
// while idle, then send the mean anomaly M (q4.28) as one slave transaction.
// the block brackets the root on [0, 4*pi] and halves until the width is at
// most twice the tolerance, or 63 halvings. one master transaction returns
// the final midpoint and the halving count. a single sine unit does all the
// work: each function evaluation runs load, reduce (up to two modulo
// subtractions), fold, 30 cordic rotations (skipped when the folded angle
// is zero), scale and sign, and the value at the lower bound is reused.
// the block takes no new item until its result is registered; the result
// then waits in the output register.
module kepler_equation_bisection_solver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [kepler_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] mean_anomaly
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [31:0] eccentric_anomaly, [37:32] iterations
);

    localparam int AW = kepler_pkg::ANGLE_W;

    kepler_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [kepler_pkg::ECC_W-1:0] ecc_reg;
    logic [AW-1:0]                tol_reg;

    // bracket and sequencing state
    logic [AW-1:0] low_reg, low_next;
    logic [AW-1:0] high_reg, high_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic [kepler_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic          init_reg, init_next;      // evaluating f(low) at start
    logic          fa_neg_reg, fa_neg_next, fa_zero_reg, fa_zero_next;
    logic          fc_neg_reg, fc_neg_next, fc_zero_reg, fc_zero_next;
    logic [kepler_pkg::Q30_W-1:0] mq_reg, mq_next;     // M in q30
    logic [kepler_pkg::Q30_W-1:0] eq_reg, eq_next;     // E under test, q30

    // shared sine unit datapath
    logic signed [kepler_pkg::RED_W-1:0] r_reg, r_next;
    logic signed [kepler_pkg::XY_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [kepler_pkg::STAGE_W-1:0]      i_reg, i_next;
    logic [kepler_pkg::ES_W-1:0]         es_reg, es_next;
    logic                                yneg_reg, yneg_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] out_e_reg, out_e_next;
    logic [kepler_pkg::COUNT_W-1:0] out_n_reg, out_n_next;

    // combinational helpers
    logic [AW:0]   sum_w;
    logic [AW-1:0] width_w;
    logic          more_w;
    logic signed [kepler_pkg::RED_W-1:0] fold_w, wrap_w, atan_w;
    logic signed [kepler_pkg::XY_W-1:0]  xs_w, ys_w;
    logic [kepler_pkg::ES_W-1:0]         mag_w;
    logic [kepler_pkg::ECC_W+kepler_pkg::ES_W-1:0] prod_w;
    logic signed [kepler_pkg::F_W-1:0]   f_w, es_s_w;
    logic          out_free_w;

    assign s_tready   = (state_reg == kepler_pkg::ST_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {2'b00, out_n_reg, out_e_reg};
    assign out_free_w = !out_valid_reg || m_tready;

    assign sum_w   = {1'b0, high_reg} + {1'b0, low_reg};
    assign width_w = high_reg - low_reg;
    // continue while width > 2 * tolerance and under the step limit
    assign more_w  = ({1'b0, width_w} > {tol_reg, 1'b0})
                     && (cnt_reg != kepler_pkg::STEP_LIMIT);

    // fold reduced angle into [-pi/2, pi/2]
    always_comb begin
        wrap_w = (r_reg > $signed(kepler_pkg::PI_Q30))
                 ? r_reg - $signed(kepler_pkg::TWO_PI_Q30) : r_reg;
        if (wrap_w > $signed(kepler_pkg::HALF_PI_Q30)) begin
            fold_w = $signed(kepler_pkg::PI_Q30) - wrap_w;
        end else if (wrap_w < -$signed(kepler_pkg::HALF_PI_Q30)) begin
            fold_w = -$signed(kepler_pkg::PI_Q30) - wrap_w;
        end else begin
            fold_w = wrap_w;
        end
    end

    assign atan_w = $signed({4'b0000, kepler_pkg::atan_lut(i_reg)});
    assign xs_w   = x_reg >>> i_reg;
    assign ys_w   = y_reg >>> i_reg;

    assign mag_w  = y_reg[kepler_pkg::XY_W-1] ? kepler_pkg::ES_W'(-y_reg)
                                              : kepler_pkg::ES_W'(y_reg);
    assign prod_w = ecc_reg * mag_w;

    assign es_s_w = yneg_reg ? -$signed({5'b00000, es_reg}) : $signed({5'b00000, es_reg});
    assign f_w    = $signed({4'b0000, eq_reg}) - es_s_w - $signed({4'b0000, mq_reg});

    always_comb begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        cnt_next       = cnt_reg;
        init_next      = init_reg;
        fa_neg_next    = fa_neg_reg;
        fa_zero_next   = fa_zero_reg;
        fc_neg_next    = fc_neg_reg;
        fc_zero_next   = fc_zero_reg;
        mq_next        = mq_reg;
        eq_next        = eq_reg;
        r_next         = r_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        i_next         = i_reg;
        es_next        = es_reg;
        yneg_next      = yneg_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_e_next     = out_e_reg;
        out_n_next     = out_n_reg;

        case (state_reg)
            kepler_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    mq_next    = {s_tdata, 2'b00};
                    low_next   = '0;
                    high_next  = kepler_pkg::FOUR_PI_ANGLE;
                    cnt_next   = '0;
                    init_next  = 1'b1;
                    eq_next    = '0;       // first evaluation at the lower bound
                    state_next = kepler_pkg::ST_LOAD;
                end
            end
            kepler_pkg::ST_CHECK: begin
                if (more_w) begin
                    mid_next   = sum_w[AW:1];
                    eq_next    = {sum_w[AW:1], 2'b00};
                    init_next  = 1'b0;
                    state_next = kepler_pkg::ST_LOAD;
                end else begin
                    state_next = kepler_pkg::ST_DONE;
                end
            end
            kepler_pkg::ST_LOAD: begin
                r_next     = $signed({2'b00, eq_reg});
                state_next = kepler_pkg::ST_REDUCE;
            end
            kepler_pkg::ST_REDUCE: begin
                // modulo 2*pi by repeated subtraction, at most two passes
                if (r_reg >= $signed(kepler_pkg::TWO_PI_Q30)) begin
                    r_next = r_reg - $signed(kepler_pkg::TWO_PI_Q30);
                end else begin
                    state_next = kepler_pkg::ST_FOLD;
                end
            end
            kepler_pkg::ST_FOLD: begin
                r_next = fold_w;
                x_next = $signed(kepler_pkg::CORDIC_GAIN);
                y_next = '0;
                i_next = '0;
                // zero angle gives an exact zero sine
                state_next = (fold_w == '0) ? kepler_pkg::ST_SCALE : kepler_pkg::ST_ROTATE;
            end
            kepler_pkg::ST_ROTATE: begin
                if (!r_reg[kepler_pkg::RED_W-1]) begin
                    x_next = x_reg - ys_w;
                    y_next = y_reg + xs_w;
                    r_next = r_reg - atan_w;
                end else begin
                    x_next = x_reg + ys_w;
                    y_next = y_reg - xs_w;
                    r_next = r_reg + atan_w;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == kepler_pkg::STAGE_W'(kepler_pkg::CORDIC_STAGES - 1)) begin
                    state_next = kepler_pkg::ST_SCALE;
                end
            end
            kepler_pkg::ST_SCALE: begin
                es_next    = prod_w[kepler_pkg::ECC_FRAC_BITS +: kepler_pkg::ES_W];
                yneg_next  = y_reg[kepler_pkg::XY_W-1];
                state_next = kepler_pkg::ST_SIGN;
            end
            kepler_pkg::ST_SIGN: begin
                if (init_reg) begin
                    fa_neg_next  = f_w[kepler_pkg::F_W-1];
                    fa_zero_next = (f_w == '0);
                    state_next   = kepler_pkg::ST_CHECK;
                end else begin
                    fc_neg_next  = f_w[kepler_pkg::F_W-1];
                    fc_zero_next = (f_w == '0);
                    state_next   = kepler_pkg::ST_UPDATE;
                end
            end
            kepler_pkg::ST_UPDATE: begin
                // strict sign change between low and mid moves the upper bound
                if (!fa_zero_reg && !fc_zero_reg && (fa_neg_reg != fc_neg_reg)) begin
                    high_next = mid_reg;
                end else begin
                    low_next     = mid_reg;
                    fa_neg_next  = fc_neg_reg;
                    fa_zero_next = fc_zero_reg;
                end
                cnt_next   = cnt_reg + 1'b1;
                state_next = kepler_pkg::ST_CHECK;
            end
            kepler_pkg::ST_DONE: begin
                if (out_free_w) begin
                    out_valid_next = 1'b1;
                    out_e_next     = sum_w[AW:1];
                    out_n_next     = cnt_reg;
                    state_next     = kepler_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kepler_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kepler_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            ecc_reg       <= '0;
            tol_reg       <= 32'd1;
            low_reg       <= '0;
            high_reg      <= '0;
            cnt_reg       <= '0;
            init_reg      <= 1'b0;
            i_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            cnt_reg       <= cnt_next;
            init_reg      <= init_next;
            i_reg         <= i_next;
            if (cfg_wr_en && (cfg_addr == kepler_pkg::REG_ECCENTRICITY)) begin
                ecc_reg <= cfg_wr_data[kepler_pkg::ECC_W-1:0];
            end
            if (cfg_wr_en && (cfg_addr == kepler_pkg::REG_TOLERANCE)) begin
                tol_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mid_reg     <= mid_next;
        fa_neg_reg  <= fa_neg_next;
        fa_zero_reg <= fa_zero_next;
        fc_neg_reg  <= fc_neg_next;
        fc_zero_reg <= fc_zero_next;
        mq_reg      <= mq_next;
        eq_reg      <= eq_next;
        r_reg       <= r_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        es_reg      <= es_next;
        yneg_reg    <= yneg_next;
        out_e_reg   <= out_e_next;
        out_n_reg   <= out_n_next;
    end

    // bracket stays ordered
    a_bracket_order: assert property (@(posedge aclk) disable iff (!aresetn)
        low_reg <= high_reg)
        else $error("bracket low above high");

    // accepted transaction starts a sine evaluation
    a_accept_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == kepler_pkg::ST_LOAD))
        else $error("accept did not start evaluation");

    // reduction leaves the angle below 2*pi
    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kepler_pkg::ST_FOLD) |->
        (r_reg < $signed(kepler_pkg::TWO_PI_Q30)))
        else $error("angle not reduced");

    // cordic index stays within the stage count
    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kepler_pkg::ST_ROTATE) |->
        (i_reg < kepler_pkg::STAGE_W'(kepler_pkg::CORDIC_STAGES)))
        else $error("cordic stage out of range");

    // finished result lands in a free output register
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kepler_pkg::ST_DONE && out_free_w) |=> m_tvalid)
        else $error("result not presented");

endmodule

/* test/tb.sv */
// tb: self-checking testbench for kepler_equation_bisection_solver. a local
// predictor models the bisection and cordic sine; depends on kepler_pkg and the rtl.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned FOUR_PI_A = 64'hC90F_DAA2;
    localparam longint TWO_PI_W  = 64'd6746518852;
    localparam longint PI_W      = 64'd3373259426;
    localparam longint HALF_PI_W = 64'd1686629713;
    localparam longint GAIN_W    = 64'd652032874;
    localparam int     LIMIT_CYCLES = 5000000;

    // arctangent of 2^-i in q30, one entry per cordic rotation
    localparam longint ATAN_TBL [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

    typedef struct packed {
        logic [31:0] anomaly;
        logic [5:0]  halvings;
    } solution_t;

    typedef struct {
        logic [15:0] ecc;
        logic [31:0] tol;
        logic [31:0] mean;
        bit          typed;      // expected value written in the row
        logic [31:0] e_exp;
        logic [5:0]  n_exp;
    } vector_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [kepler_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    solution_t      solutions_due[$];
    longint unsigned ecc_cur = 0;
    longint unsigned tol_cur = 1;
    int             mismatches = 0;
    int             cycle_count = 0;
    int             stall_left = 0;
    bit             rx_idle_run = 1'b0;

    kepler_equation_bisection_solver dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // cordic sine in q30 of a nonnegative q30 angle
    function automatic longint cordic_sine(longint ang);
        longint r, x, y, nx;
        r = ang % TWO_PI_W;
        x = GAIN_W;
        y = 0;
        if (r > PI_W) r = r - TWO_PI_W;
        if (r > HALF_PI_W) r = PI_W - r;
        else if (r < -HALF_PI_W) r = -PI_W - r;
        // exact zero of the reduced angle: no rotation residue
        if (r == 0) return 0;
        for (int i = 0; i < 30; i++) begin
            if (r >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                r  = r - ATAN_TBL[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                r  = r + ATAN_TBL[i];
            end
            x = nx;
        end
        return y;
    endfunction

    // sign of E - e*sin(E) - M
    function automatic int kepler_residual_sign(longint unsigned e_ang, longint m30);
        longint e30, s, es, f;
        longint unsigned mag;
        e30 = longint'(e_ang << 2);
        s   = cordic_sine(e30);
        mag = (s < 0) ? longint'(-s) : s;
        es  = longint'((ecc_cur * mag) >> kepler_pkg::ECC_FRAC_BITS);
        if (s < 0) es = -es;
        f = e30 - es - m30;
        return (f > 0) ? 1 : ((f < 0) ? -1 : 0);
    endfunction

    function automatic solution_t solve_kepler(logic [31:0] mean);
        longint unsigned lo, hi, mid;
        longint m30;
        int fa, fc;
        int n;
        solution_t sol;
        m30 = longint'({32'd0, mean}) << 2;
        lo = 0;
        hi = FOUR_PI_A;
        n  = 0;
        while (hi - lo > 2 * tol_cur && n < 63) begin
            mid = (hi + lo) >> 1;
            fa = kepler_residual_sign(lo, m30);
            fc = kepler_residual_sign(mid, m30);
            if (fa * fc < 0) hi = mid;
            else lo = mid;
            n++;
        end
        sol.anomaly  = 32'((hi + lo) >> 1);
        sol.halvings = 6'(n);
        return sol;
    endfunction

    // drives one write; the caller drops the enable afterwards
    task automatic write_reg(logic [kepler_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        if (idx == kepler_pkg::REG_ECCENTRICITY) ecc_cur = val[15:0];
        else tol_cur = val;
    endtask

    // block is idle once every result is back; the writes follow after a margin
    task automatic settle_and_configure(logic [15:0] ecc, logic [31:0] tol);
        while (solutions_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        write_reg(kepler_pkg::REG_ECCENTRICITY, {16'd0, ecc});
        write_reg(kepler_pkg::REG_TOLERANCE, tol);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // one slave transaction; valid stays high across back-to-back items
    task automatic send_anomaly(logic [31:0] mean, bit typed, solution_t typed_sol);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mean;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        solutions_due.push_back(typed ? typed_sol : solve_kepler(mean));
    endtask

    function automatic logic [31:0] random_anomaly();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 32'hC90F_DAA2);
        if (r < 90) return $urandom();        // often beyond 4*pi
        return (r < 95) ? 32'd0 : 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] random_tolerance();
        int r;
        r = $urandom_range(0, 5);
        case (r)
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 255);
            3: return $urandom_range(256, 32'h000F_FFFF);
            default: return $urandom();
        endcase
    endfunction

    // result side: random backpressure, compare against the oldest expectation
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb failed");
            $finish;
        end else begin
            if (m_tvalid && m_tready && aresetn) begin
                if (solutions_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %h", m_tdata);
                end else begin
                    solution_t want;
                    want = solutions_due.pop_front();
                    if (m_tdata[31:0] !== want.anomaly || m_tdata[37:32] !== want.halvings) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: E exp %h got %h, steps exp %0d got %0d",
                                     want.anomaly, m_tdata[31:0], want.halvings,
                                     m_tdata[37:32]);
                    end
                end
            end
            // mostly short stalls, a few long ones, with stretches of none
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else if (rx_idle_run) begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 999) == 0) rx_idle_run <= 1'b0;
            end else begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 60) m_tready <= 1'b1;
                else if (r < 95) begin
                    m_tready   <= 1'b0;
                    stall_left <= $urandom_range(0, 3);
                end else if (r < 98) begin
                    m_tready   <= 1'b0;
                    stall_left <= $urandom_range(20, 300);
                end else begin
                    m_tready    <= 1'b1;
                    rx_idle_run <= 1'b1;
                end
            end
        end
    end

    vector_t directed[$];

    initial begin
        vector_t v;
        solution_t none;
        none = '0;
        // wide tolerance: no halving at all, result is the bracket midpoint
        directed.push_back('{16'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'h6487_ED51, 6'd0});
        directed.push_back('{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                             32'h6487_ED51, 6'd0});
        directed.push_back('{16'd0, 32'h6487_ED51, 32'h1234_5678, 1'b1, 32'h6487_ED51, 6'd0});
        // the rest go through the predictor
        directed.push_back('{16'd0, 32'd1, 32'd0, 1'b0, 32'd0, 6'd0});           // zero at bound
        directed.push_back('{16'd0, 32'd1, 32'hC90F_DAA2, 1'b0, 32'd0, 6'd0});   // M at 4*pi
        directed.push_back('{16'd0, 32'd1, 32'hFFFF_FFFF, 1'b0, 32'd0, 6'd0});   // beyond 4*pi
        directed.push_back('{16'hFFFF, 32'd1, 32'd0, 1'b0, 32'd0, 6'd0});
        directed.push_back('{16'hFFFF, 32'd1, 32'h3243_F6A8, 1'b0, 32'd0, 6'd0}); // near pi
        directed.push_back('{16'hFFFF, 32'd1, 32'h6487_ED51, 1'b0, 32'd0, 6'd0}); // near 2*pi
        directed.push_back('{16'hFFFF, 32'd1, 32'h96CB_E3F9, 1'b0, 32'd0, 6'd0}); // near 3*pi
        directed.push_back('{16'hFFFF, 32'd1, 32'hC90F_DAA2, 1'b0, 32'd0, 6'd0});
        directed.push_back('{16'hFFFF, 32'd1, 32'hFFFF_FFFF, 1'b0, 32'd0, 6'd0});
        directed.push_back('{16'h8000, 32'd1, 32'h1000_0000, 1'b0, 32'd0, 6'd0});
        directed.push_back('{16'h8000, 32'd0, 32'h2000_0000, 1'b0, 32'd0, 6'd0}); // tolerance 0
        directed.push_back('{16'hFFFF, 32'd0, 32'h0000_0001, 1'b0, 32'd0, 6'd0});
        directed.push_back('{16'h4000, 32'h0000_1000, 32'h5555_5555, 1'b0, 32'd0, 6'd0});
        directed.push_back('{16'hC000, 32'h0100_0000, 32'hAAAA_AAAA, 1'b0, 32'd0, 6'd0});
        directed.push_back('{16'h0001, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'd0, 6'd0});

        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: eccentricity 0, tolerance 1
        send_anomaly(32'h1000_0000, 1'b0, none);

        foreach (directed[i]) begin
            v = directed[i];
            if (v.ecc != ecc_cur[15:0] || v.tol != tol_cur[31:0]) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                settle_and_configure(v.ecc, v.tol);
            end
            send_anomaly(v.mean, v.typed, '{v.e_exp, v.n_exp});
        end

        // random phases, each under its own setting
        for (int p = 0; p < 12; p++) begin
            logic [15:0] e;
            int sel;
            sel = $urandom_range(0, 3);
            e = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : 16'($urandom());
            s_tvalid <= 1'b0;
            @(posedge aclk);
            settle_and_configure(e, random_tolerance());
            for (int k = 0; k < 43; k++) send_anomaly(random_anomaly(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (solutions_due.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

/* kepler_equation_bisection_solver.f */
hw/rtl/kepler_pkg.sv
hw/rtl/kepler_equation_bisection_solver.sv
test/tb.sv
